// ===== design/rpy_pkg.sv =====
// Shared types, constants and CORDIC angle table for the pose transform.
package rpy_pkg;

    localparam int unsigned ATAN_ENTRIES = 24;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [33:0] HALF_PI_Q29 = 34'sd843314857;
    localparam logic signed [33:0] PI_Q29      = 34'sd1686629713;

    typedef logic signed [31:0] t_coord;
    typedef logic signed [15:0] t_angle;
    // sine/cosine and matrix entries in Q2.30 with headroom
    typedef logic signed [33:0] t_q30;

    typedef struct packed {
        t_coord point_x;
        t_coord point_y;
        t_coord point_z;
        t_coord pos_x;
        t_coord pos_y;
        t_coord pos_z;
        t_angle roll;
        t_angle pitch;
        t_angle yaw;
    } t_in_item;

    typedef struct packed {
        t_coord world_x;
        t_coord world_y;
        t_coord world_z;
    } t_out_item;

    function automatic t_q30 atan_q29(input int unsigned idx);
        t_q30 v;
        case (idx)
            0: v = 34'sd421657428;
            1: v = 34'sd248918915;
            2: v = 34'sd131521918;
            3: v = 34'sd66762579;
            4: v = 34'sd33510843;
            5: v = 34'sd16771758;
            6: v = 34'sd8387925;
            7: v = 34'sd4194219;
            8: v = 34'sd2097141;
            9: v = 34'sd1048575;
            default: v = t_q30'(34'sd1 <<< (29 - idx));
        endcase
        return v;
    endfunction

    // Q2.30 product rounded half up: (a*b + 2^29) >>> 30
    function automatic t_q30 mul30(input t_q30 a, input t_q30 b);
        logic signed [67:0] p;
        p = a * b + 68'sd536870912;
        return t_q30'(p >>> 30);
    endfunction

    // Q2.30 times Q16.16 rounded to Q16.16
    function automatic logic signed [35:0] mulpt(input t_q30 a, input t_coord b);
        logic signed [65:0] p;
        p = a * b + 66'sd536870912;
        return 36'(p >>> 30);
    endfunction

endpackage

// ===== design/rpy_stream_if.sv =====
// Valid/ready stream channel carrying one payload.
interface rpy_stream_if #(parameter type T = logic) (input logic i_clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/rpy_pose_point_transform.sv =====
// Top level of the roll-pitch-yaw point transform pipeline.
// Usage:
//  in_ch (sink) transfers a body-frame point, a translation and three
//  angles (Q16.16 / Q3.13); out_ch (source) transfers the world point.
//  From input transfer to output valid: one fold stage, one stage
//  per CORDIC step (CORDIC_STEPS, capped at 24), then pair products,
//  triple products (matrix), point terms, and the sum and saturate
//  stage, which is the output register. Throughput: one item per
//  cycle when not stalled; every stage is at most one multiplier deep.
//  Stall: the whole pipeline advances on one enable, which is high
//  when the output register is empty or is being taken. A stalled
//  receiver freezes every stage; valid bits travel with the data, so
//  nothing is lost or repeated. in_ch.ready follows that enable.
//  Reset: synchronous, active low; clears all valid bits. Payload
//  registers carry no reset.
module rpy_pose_point_transform #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    rpy_stream_if.sink   in_ch,
    rpy_stream_if.source out_ch
);
    import rpy_pkg::*;

    localparam int NS  = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
    localparam int LAT = NS + 1;   // stages through the CORDIC

    logic w_en;
    // advance when output is empty or being taken
    assign w_en = !out_ch.valid || out_ch.ready;
    assign in_ch.ready = w_en;

    t_in_item w_in;
    assign w_in = in_ch.data;

    // valid and side data alongside the CORDIC
    logic     r_v [LAT+4];
    t_coord   r_pt [LAT][3];
    t_coord   r_tr [LAT][3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT + 4; k++) r_v[k] <= 1'b0;
        end else if (w_en) begin
            r_v[0] <= in_ch.valid;
            for (int k = 1; k < LAT + 4; k++) r_v[k] <= r_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pt[0][0] <= w_in.point_x; r_pt[0][1] <= w_in.point_y;
            r_pt[0][2] <= w_in.point_z;
            r_tr[0][0] <= w_in.pos_x; r_tr[0][1] <= w_in.pos_y;
            r_tr[0][2] <= w_in.pos_z;
            for (int k = 1; k < LAT; k++) begin
                r_pt[k] <= r_pt[k-1];
                r_tr[k] <= r_tr[k-1];
            end
        end
    end

    t_angle w_ang [3];
    t_q30   w_cos [3];
    t_q30   w_sin [3];
    assign w_ang[0] = w_in.roll;
    assign w_ang[1] = w_in.pitch;
    assign w_ang[2] = w_in.yaw;

    rpy_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_ang (w_ang),
        .o_cos (w_cos),
        .o_sin (w_sin)
    );

    // index 0 roll (g), 1 pitch (b), 2 yaw (a)
    t_q30 r_cacb, r_casb, r_sacb, r_sasb, r_sacg, r_sasg, r_cacg, r_casg;
    t_q30 r_cbsg, r_cbcg, r_sg1, r_cg1, r_nsb1;
    t_q30 r_m [3][3];
    t_coord r_pt2 [2][3];
    t_coord r_tr2 [2][3];
    logic signed [35:0] r_term [3][3];
    t_coord r_tr3 [3];
    t_coord r_world [3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // pair products
            r_cacb <= mul30(w_cos[2], w_cos[1]);
            r_casb <= mul30(w_cos[2], w_sin[1]);
            r_sacb <= mul30(w_sin[2], w_cos[1]);
            r_sasb <= mul30(w_sin[2], w_sin[1]);
            r_sacg <= mul30(w_sin[2], w_cos[0]);
            r_sasg <= mul30(w_sin[2], w_sin[0]);
            r_cacg <= mul30(w_cos[2], w_cos[0]);
            r_casg <= mul30(w_cos[2], w_sin[0]);
            r_cbsg <= mul30(w_cos[1], w_sin[0]);
            r_cbcg <= mul30(w_cos[1], w_cos[0]);
            r_sg1  <= w_sin[0];
            r_cg1  <= w_cos[0];
            r_nsb1 <= -w_sin[1];
            r_pt2[0] <= r_pt[LAT-1];
            r_tr2[0] <= r_tr[LAT-1];
            // matrix
            r_m[0][0] <= r_cacb;
            r_m[0][1] <= mul30(r_casb, r_sg1) - r_sacg;
            r_m[0][2] <= mul30(r_casb, r_cg1) + r_sasg;
            r_m[1][0] <= r_sacb;
            r_m[1][1] <= mul30(r_sasb, r_sg1) + r_cacg;
            r_m[1][2] <= mul30(r_sasb, r_cg1) - r_casg;
            r_m[2][0] <= r_nsb1;
            r_m[2][1] <= r_cbsg;
            r_m[2][2] <= r_cbcg;
            r_pt2[1] <= r_pt2[0];
            r_tr2[1] <= r_tr2[0];
            // point terms
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    r_term[r][c] <= mulpt(r_m[r][c], r_pt2[1][c]);
            r_tr3 <= r_tr2[1];
            // sum and saturate
            for (int r = 0; r < 3; r++) begin
                logic signed [37:0] acc;
                acc = 38'(r_term[r][0]) + 38'(r_term[r][1]) + 38'(r_term[r][2])
                    + 38'(r_tr3[r]);
                if (acc > 38'sd2147483647)       r_world[r] <= 32'sh7fffffff;
                else if (acc < -38'sd2147483648) r_world[r] <= 32'sh80000000;
                else                             r_world[r] <= acc[31:0];
            end
        end
    end

    t_out_item w_out;
    assign w_out.world_x = r_world[0];
    assign w_out.world_y = r_world[1];
    assign w_out.world_z = r_world[2];
    assign out_ch.data  = w_out;
    assign out_ch.valid = r_v[LAT+3];
endmodule

// ===== design/rpy_cordic.sv =====
// Pipelined CORDIC: cosine and sine of three angles, one stage per step.
module rpy_cordic #(
    parameter int STEPS = 16
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  rpy_pkg::t_angle   i_ang [3],
    output rpy_pkg::t_q30     o_cos [3],
    output rpy_pkg::t_q30     o_sin [3]
);
    import rpy_pkg::*;

    localparam int NS = (STEPS > 24) ? 24 : STEPS;

    t_q30 r_x [NS+1][3];
    t_q30 r_y [NS+1][3];
    t_q30 r_z [NS+1][3];
    logic r_neg [NS+1][3];

    // range fold into -pi/2..pi/2
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int a = 0; a < 3; a++) begin
                t_q30 z;
                z = t_q30'(i_ang[a]) <<< 16;
                r_x[0][a] <= CORDIC_GAIN;
                r_y[0][a] <= '0;
                if (z > HALF_PI_Q29) begin
                    r_z[0][a] <= z - PI_Q29;
                    r_neg[0][a] <= 1'b1;
                end else if (z < -HALF_PI_Q29) begin
                    r_z[0][a] <= z + PI_Q29;
                    r_neg[0][a] <= 1'b1;
                end else begin
                    r_z[0][a] <= z;
                    r_neg[0][a] <= 1'b0;
                end
            end
        end
    end

    for (genvar s = 0; s < NS; s++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int a = 0; a < 3; a++) begin
                    r_neg[s+1][a] <= r_neg[s][a];
                    if (!r_z[s][a][33]) begin
                        r_x[s+1][a] <= r_x[s][a] - (r_y[s][a] >>> s);
                        r_y[s+1][a] <= r_y[s][a] + (r_x[s][a] >>> s);
                        r_z[s+1][a] <= r_z[s][a] - atan_q29(s);
                    end else begin
                        r_x[s+1][a] <= r_x[s][a] + (r_y[s][a] >>> s);
                        r_y[s+1][a] <= r_y[s][a] - (r_x[s][a] >>> s);
                        r_z[s+1][a] <= r_z[s][a] + atan_q29(s);
                    end
                end
            end
        end
    end

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            o_cos[a] = r_neg[NS][a] ? -r_x[NS][a] : r_x[NS][a];
            o_sin[a] = r_neg[NS][a] ? -r_y[NS][a] : r_y[NS][a];
        end
    end
endmodule

// ===== design/rpy_checker.sv =====
// Port-level checker for the pose transform, bound to the top level.
module rpy_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready
);
    // input ready is high whenever the output is free to move
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!out_valid || out_ready) |-> in_ready) else $error("ready low with free output");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && !out_ready) |-> !in_ready) else $error("ready high while stalled");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && !out_ready) |=> out_valid) else $error("output valid dropped");
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid) else $error("valid after reset");
endmodule

bind rpy_pose_point_transform rpy_checker u_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready)
);
